FILE: rtl/tlv_frame_parser_checksum_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the TLV frame parser
// Clocked implication checks that are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef TLV_FRAME_PARSER_CHECKSUM_UNIT_ASSERT_SVH
`define TLV_FRAME_PARSER_CHECKSUM_UNIT_ASSERT_SVH

// same-cycle implication
`define TLVFP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlvfp assertion failed");

// next-cycle implication
`define TLVFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlvfp assertion failed");

`endif

FILE: rtl/tlvfp_pkg.sv
// ---------------------------------------------------------------------------
// TLV frame parser package
// Parse phases, field kind codes, the header reset value and the checksum base shared by the design.
// ---------------------------------------------------------------------------
package tlvfp_pkg;

   localparam logic [7:0] HEADER_RESET = 8'h2E;
   localparam logic [7:0] SUM_BASE     = 8'hFF;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TYPE = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAY  = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_TYPE   = 3'd1,
      KIND_LEN    = 3'd2,
      KIND_PAY    = 3'd3,
      KIND_SUM    = 3'd4
   } field_kind_type;

endpackage

FILE: rtl/tlv_frame_parser_checksum_unit.sv
// A byte accepted into the input register shows its result on rsp_ from the result register.
// Throughput: one byte per cycle; the input register and the result register
// each move every cycle unless the result register is held by rsp_stall.
// Bytes outside a frame other than the header value produce no result.
// Reset (synchronous): parser idle, no result pending, header value 0x2E.
// ---------------------------------------------------------------------------
// TLV frame parser with 8-bit complement checksum
// Input register, single-pass field decode and checksum, result register.
// ---------------------------------------------------------------------------
module tlv_frame_parser_checksum_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic [2:0] rsp_field_kind,
   output logic [7:0] rsp_frame_type,
   output logic       rsp_frame_end,
   output logic       rsp_checksum_ok,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_header_byte
);

   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_byte_ff;
   logic [7:0]           header_ff, header_in;

   tlvfp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           ftype_ff, ftype_in;
   logic [7:0]           plen_ff, plen_in;
   logic [7:0]           pcnt_ff, pcnt_in;
   logic [7:0]           psum_ff, psum_in;

   logic                 out_vld_ff, out_vld_in;
   logic [7:0]           out_echo_ff;
   logic [2:0]           out_kind_ff;
   logic [7:0]           out_ftype_ff;
   logic                 out_end_ff;
   logic                 out_ok_ff;

   logic                 emit;
   logic [2:0]           emit_kind;
   logic [7:0]           emit_ftype;
   logic                 emit_end;
   logic                 emit_ok;
   logic                 out_free;
   logic                 advance;
   logic                 load_out;
   logic [7:0]           cnt_next;
   logic [7:0]           sum_next;

   assign csr_ready = 1'b1;
   assign header_in = (csr_valid && csr_ready) ? csr_header_byte : header_ff;

   assign out_free = !out_vld_ff || !rsp_stall;
   // a byte that yields nothing may leave the input register even when the result is held
   assign advance  = in_vld_ff && (out_free || !emit);
   assign load_out = advance && emit;

   assign req_stall = in_vld_ff && !advance;
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !advance);
   assign out_vld_in = load_out || (out_vld_ff && rsp_stall);

   assign cnt_next = pcnt_ff + 8'd1;
   assign sum_next = psum_ff + in_byte_ff;

   always_comb begin
      phase_in   = phase_ff;
      ftype_in   = ftype_ff;
      plen_in    = plen_ff;
      pcnt_in    = pcnt_ff;
      psum_in    = psum_ff;
      emit       = 1'b1;
      emit_kind  = tlvfp_pkg::KIND_HEADER;
      emit_ftype = ftype_ff;
      emit_end   = 1'b0;
      emit_ok    = 1'b0;
      unique case (phase_ff)
         tlvfp_pkg::PH_TYPE: begin
            ftype_in   = in_byte_ff;
            phase_in   = tlvfp_pkg::PH_LEN;
            emit_kind  = tlvfp_pkg::KIND_TYPE;
            emit_ftype = in_byte_ff;
         end
         tlvfp_pkg::PH_LEN: begin
            plen_in   = in_byte_ff;
            pcnt_in   = 8'd0;
            psum_in   = 8'd0;
            phase_in  = (in_byte_ff == 8'd0) ? tlvfp_pkg::PH_SUM : tlvfp_pkg::PH_PAY;
            emit_kind = tlvfp_pkg::KIND_LEN;
         end
         tlvfp_pkg::PH_PAY: begin
            psum_in   = sum_next;
            pcnt_in   = cnt_next;
            if (cnt_next >= plen_ff) begin
               phase_in = tlvfp_pkg::PH_SUM;
            end
            emit_kind = tlvfp_pkg::KIND_PAY;
         end
         tlvfp_pkg::PH_SUM: begin
            phase_in  = tlvfp_pkg::PH_IDLE;
            emit_kind = tlvfp_pkg::KIND_SUM;
            emit_end  = 1'b1;
            emit_ok   = (in_byte_ff == (tlvfp_pkg::SUM_BASE - psum_ff));
         end
         default: begin
            // idle, and any unused phase code: wait for the header value
            emit       = (in_byte_ff == header_ff);
            phase_in   = emit ? tlvfp_pkg::PH_TYPE : tlvfp_pkg::PH_IDLE;
            emit_ftype = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         header_ff  <= tlvfp_pkg::HEADER_RESET;
         phase_ff   <= tlvfp_pkg::PH_IDLE;
         ftype_ff   <= 8'd0;
         plen_ff    <= 8'd0;
         pcnt_ff    <= 8'd0;
         psum_ff    <= 8'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         header_ff  <= header_in;
         if (advance) begin
            phase_ff <= phase_in;
            ftype_ff <= ftype_in;
            plen_ff  <= plen_in;
            pcnt_ff  <= pcnt_in;
            psum_ff  <= psum_in;
         end
      end
   end

   // payload registers: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (load_out) begin
         out_echo_ff  <= in_byte_ff;
         out_kind_ff  <= emit_kind;
         out_ftype_ff <= emit_ftype;
         out_end_ff   <= emit_end;
         out_ok_ff    <= emit_ok;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_echo_byte   = out_echo_ff;
   assign rsp_field_kind  = out_kind_ff;
   assign rsp_frame_type  = out_ftype_ff;
   assign rsp_frame_end   = out_end_ff;
   assign rsp_checksum_ok = out_ok_ff;

endmodule

FILE: rtl/tlvfp_checker.sv
// ---------------------------------------------------------------------------
// TLV frame parser port checker
// Watches the result channel of the parser and checks tag consistency.
// ---------------------------------------------------------------------------
`include "tlv_frame_parser_checksum_unit_assert.svh"

module tlvfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_echo_byte,
   input logic [2:0] rsp_field_kind,
   input logic [7:0] rsp_frame_type,
   input logic       rsp_frame_end,
   input logic       rsp_checksum_ok
);

   // hold a stalled result
   `TLVFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_echo_byte) && $stable(rsp_field_kind) && $stable(rsp_frame_end))

   `TLVFP_ASSERT_SAME(a_end_is_sum, clock, reset, rsp_valid && rsp_frame_end, rsp_field_kind == tlvfp_pkg::KIND_SUM)

   `TLVFP_ASSERT_SAME(a_ok_needs_end, clock, reset, rsp_valid && rsp_checksum_ok, rsp_frame_end)

   `TLVFP_ASSERT_SAME(a_header_no_type, clock, reset, rsp_valid && (rsp_field_kind == tlvfp_pkg::KIND_HEADER), rsp_frame_type == 8'd0)

   `TLVFP_ASSERT_SAME(a_type_echo, clock, reset, rsp_valid && (rsp_field_kind == tlvfp_pkg::KIND_TYPE), rsp_frame_type == rsp_echo_byte)

endmodule

bind tlv_frame_parser_checksum_unit tlvfp_checker u_tlvfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_echo_byte   (rsp_echo_byte),
   .rsp_field_kind  (rsp_field_kind),
   .rsp_frame_type  (rsp_frame_type),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_checksum_ok (rsp_checksum_ok)
);
